// File: hdl/swcd_pkg.sv
// shared types, constants and register codes of the sliding-window critical detector
`default_nettype none

package swcd_pkg;

  localparam int READING_W      = 16;
  localparam int LIMIT_W        = 15;
  localparam int LOW_CNT_W      = 3;
  localparam int CRIT_COUNT_W   = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 16;

  localparam int DEF_WINDOW_LEN = 5;
  localparam int DEF_COUNT_BITS = 16;

  localparam logic [LIMIT_W-1:0]           RST_VALID_MAX     = 15'd150;
  localparam logic signed [READING_W-1:0]  RST_LOW_LIMIT     = 16'sd70;
  localparam logic [LIMIT_W-1:0]           RST_AVG_MIN       = 15'd90;
  localparam logic [LOW_CNT_W-1:0]         RST_LOW_COUNT_MAX = 3'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VALID_MAX     = 2'd0,
    REG_LOW_LIMIT     = 2'd1,
    REG_AVG_MIN       = 2'd2,
    REG_LOW_COUNT_MAX = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [LIMIT_W-1:0]          valid_max;
    logic signed [READING_W-1:0] low_limit;
    logic [LIMIT_W-1:0]          avg_min;
    logic [LOW_CNT_W-1:0]        low_count_max;
  } cfg_t;

  // control word handed from the window stage to the evaluation stage
  typedef struct packed {
    logic valid;
    logic start;
    logic full;
  } stage_ctl_t;

endpackage

`default_nettype wire

// File: hdl/swcd_in_if.sv
// input channel: one reading and a start-of-series flag per transfer
`default_nettype none

interface swcd_in_if
  import swcd_pkg::*;
();
  logic                        valid;
  logic                        ready;
  logic signed [READING_W-1:0] reading;
  logic                        start_of_series;

  modport source (output valid, output reading, output start_of_series, input ready);
  modport sink   (input valid, input reading, input start_of_series, output ready);
endinterface

`default_nettype wire

// File: hdl/swcd_out_if.sv
// result channel: window status and running critical count per transfer
`default_nettype none

interface swcd_out_if
  import swcd_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic                    window_full;
  logic                    window_critical;
  logic [CRIT_COUNT_W-1:0] critical_count;

  modport source (output valid, output window_full, output window_critical,
                  output critical_count, input ready);
  modport sink   (input valid, input window_full, input window_critical,
                  input critical_count, output ready);
endinterface

`default_nettype wire

// File: hdl/sliding_window_critical_detector.sv
// an input transfer passes the window register, then the result register
// throughput: one reading per cycle unless out_chan stalls; the judging logic sits
//   between the window shift and result registers; the count register feeds itself
// reset: synchronous active-low rst_n clears the fill level, stage valids and the count,
//   and loads the thresholds with 150, 70, 90 and 3
`default_nettype none

module sliding_window_critical_detector
  import swcd_pkg::*;
#(
  parameter int WINDOW_LEN = DEF_WINDOW_LEN,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  swcd_in_if.sink                    in_chan,
  swcd_out_if.source                 out_chan,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t                                 cfg_r, cfg_nxt;
  stage_ctl_t                           ctl;
  logic [WINDOW_LEN-1:0][READING_W-1:0] win;
  logic                                 take;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_VALID_MAX:     cfg_nxt.valid_max     = cfg_wdata[LIMIT_W-1:0];
        REG_LOW_LIMIT:     cfg_nxt.low_limit     = $signed(cfg_wdata[READING_W-1:0]);
        REG_AVG_MIN:       cfg_nxt.avg_min       = cfg_wdata[LIMIT_W-1:0];
        REG_LOW_COUNT_MAX: cfg_nxt.low_count_max = cfg_wdata[LOW_CNT_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.valid_max     <= RST_VALID_MAX;
      cfg_r.low_limit     <= RST_LOW_LIMIT;
      cfg_r.avg_min       <= RST_AVG_MIN;
      cfg_r.low_count_max <= RST_LOW_COUNT_MAX;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  swcd_window #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .take    (take),
    .ctl     (ctl),
    .win     (win)
  );

  swcd_eval #(
    .WINDOW_LEN (WINDOW_LEN),
    .COUNT_BITS (COUNT_BITS)
  ) u_eval (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .ctl      (ctl),
    .win      (win),
    .take     (take),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire

// File: hdl/swcd_window.sv
// input stage: shift register of the last readings and the series fill level
`default_nettype none

module swcd_window
  import swcd_pkg::*;
#(
  parameter int WINDOW_LEN = DEF_WINDOW_LEN
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  swcd_in_if.sink                                       in_chan,
  input  wire logic                                     take,
  output stage_ctl_t                                    ctl,
  output logic [WINDOW_LEN-1:0][READING_W-1:0]          win
);

  localparam int FILL_W = $clog2(WINDOW_LEN + 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_LEN);

  logic [WINDOW_LEN-1:0][READING_W-1:0] win_r, win_nxt;
  logic [FILL_W-1:0]                    fill_r, fill_nxt;
  stage_ctl_t                           ctl_r, ctl_nxt;
  logic                                 acc;

  assign in_chan.ready = !ctl_r.valid || take;
  assign acc           = in_chan.valid && in_chan.ready;

  always_comb begin
    win_nxt  = win_r;
    fill_nxt = fill_r;
    ctl_nxt  = ctl_r;
    if (acc) begin
      // oldest entry drops out at index 0, newest lands at the top
      for (int i = 0; i < WINDOW_LEN - 1; i++) begin
        win_nxt[i] = win_r[i+1];
      end
      win_nxt[WINDOW_LEN-1] = in_chan.reading;
      if (in_chan.start_of_series) begin
        fill_nxt = FILL_W'(1);
      end else if (fill_r < FILL_FULL) begin
        fill_nxt = fill_r + FILL_W'(1);
      end
      ctl_nxt.valid = 1'b1;
      ctl_nxt.start = in_chan.start_of_series;
      ctl_nxt.full  = (fill_nxt == FILL_FULL);
    end else if (take) begin
      ctl_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    if (!rst_n) begin
      fill_r <= '0;
      ctl_r  <= '0;
    end else begin
      fill_r <= fill_nxt;
      ctl_r  <= ctl_nxt;
    end
  end

  assign ctl = ctl_r;
  assign win = win_r;

endmodule

`default_nettype wire

// File: hdl/swcd_eval.sv
// evaluation stage: window criteria, saturating critical count and result register
`default_nettype none

module swcd_eval
  import swcd_pkg::*;
#(
  parameter int WINDOW_LEN = DEF_WINDOW_LEN,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire cfg_t                                     cfg,
  input  wire stage_ctl_t                               ctl,
  input  wire logic [WINDOW_LEN-1:0][READING_W-1:0]     win,
  output logic                                          take,
  swcd_out_if.source                                    out_chan
);

  localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
  localparam int SUM_W  = LIMIT_W + CNT_W;
  localparam int LCMP_W = (CNT_W > LOW_CNT_W) ? CNT_W : LOW_CNT_W;

  logic [CNT_W-1:0]             lows, in_range;
  logic [SUM_W-1:0]             sum, need;
  logic                         over, crit;
  logic [COUNT_BITS-1:0]        count_r, count_nxt, count_base;
  logic                         out_valid_r, out_valid_nxt;
  logic                         full_r, crit_r;
  logic [CRIT_COUNT_W-1:0]      shown;

  always_comb begin
    lows     = '0;
    in_range = '0;
    sum      = '0;
    over     = 1'b0;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      if ($signed(win[i]) > $signed({1'b0, cfg.valid_max})) begin
        over = 1'b1;
      end
      if ($signed(win[i]) < cfg.low_limit) begin
        lows = lows + CNT_W'(1);
      end
      // a non-negative reading fits in the low 15 bits
      if (!win[i][READING_W-1]) begin
        in_range = in_range + CNT_W'(1);
        sum      = sum + SUM_W'(win[i][READING_W-2:0]);
      end
    end
    need = SUM_W'(cfg.avg_min) * SUM_W'(in_range);
    crit = ctl.full && !over
           && (LCMP_W'(lows) < LCMP_W'(cfg.low_count_max))
           && (in_range != '0) && (sum >= need);
  end

  assign take = ctl.valid && (!out_valid_r || out_chan.ready);

  always_comb begin
    count_base = ctl.start ? '0 : count_r;
    count_nxt  = count_base;
    if (crit && (count_base != '1)) begin
      count_nxt = count_base + COUNT_BITS'(1);
    end
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      full_r <= ctl.full;
      crit_r <= crit;
    end
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        count_r <= count_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // count field caps at its own width when the counter is wider
  generate
    if (COUNT_BITS > CRIT_COUNT_W) begin : g_cap
      assign shown = (count_r[COUNT_BITS-1:CRIT_COUNT_W] != '0) ? '1
                                                                 : count_r[CRIT_COUNT_W-1:0];
    end else begin : g_ext
      assign shown = CRIT_COUNT_W'(count_r);
    end
  endgenerate

  assign out_chan.valid           = out_valid_r;
  assign out_chan.window_full     = full_r;
  assign out_chan.window_critical = crit_r;
  assign out_chan.critical_count  = shown;

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// testbench for the sliding-window critical detector: directed and random readings
`default_nettype none

module tb_top;
  import swcd_pkg::*;

  localparam int CLK_HALF   = 4;
  localparam int MAX_CYCLES = 1000000;
  localparam int WIN        = DEF_WINDOW_LEN;
  localparam int COUNT_SAT  = 65535;
  localparam int PHASES     = 8;
  localparam int PHASE_LEN  = 175;

  typedef struct packed {
    logic                    full;
    logic                    critical;
    logic [CRIT_COUNT_W-1:0] count;
  } window_status_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_reg_t              cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  swcd_in_if  in_chan ();
  swcd_out_if out_chan ();

  sliding_window_critical_detector DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  // local copy of thresholds and window state
  cfg_t                        limits;
  logic signed [READING_W-1:0] held [WIN];
  int                          held_cnt;
  int                          critical_total;
  window_status_t              due_status_q [$];

  int mismatches    = 0;
  int cycles        = 0;
  int in_gap_pct    = 0;
  int out_stall_pct = 0;

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= MAX_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_chan.ready <= (int'($urandom_range(99)) >= out_stall_pct);
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
  endtask

  always @(posedge clk) begin
    window_status_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (due_status_q.size() == 0) begin
        report_mismatch("result with none pending, count", out_chan.critical_count, 0);
      end else begin
        want = due_status_q.pop_front();
        if (out_chan.window_full !== want.full)
          report_mismatch("window_full", out_chan.window_full, want.full);
        if (out_chan.window_critical !== want.critical)
          report_mismatch("window_critical", out_chan.window_critical, want.critical);
        if (out_chan.critical_count !== want.count)
          report_mismatch("critical_count", out_chan.critical_count, want.count);
      end
    end
  end

  function automatic void clear_series();
    for (int i = 0; i < WIN; i++) held[i] = '0;
    held_cnt       = 0;
    critical_total = 0;
  endfunction

  function automatic logic window_meets_limits();
    longint                      sum;
    longint                      in_range;
    int                          lows;
    logic signed [READING_W-1:0] r;
    sum      = 0;
    in_range = 0;
    lows     = 0;
    for (int i = 0; i < WIN; i++) begin
      r = held[i];
      if (int'(r) > int'(limits.valid_max)) return 1'b0;
      if (r < limits.low_limit) lows++;
      if (r >= 0) begin
        sum += r;
        in_range++;
      end
    end
    if (lows >= int'(limits.low_count_max)) return 1'b0;
    // no in-range reading means no average, never critical
    if (in_range == 0) return 1'b0;
    return sum >= longint'(limits.avg_min) * in_range;
  endfunction

  function automatic window_status_t predict_window_status(
    input logic signed [READING_W-1:0] reading, input logic start);
    window_status_t st;
    if (start) clear_series();
    for (int i = 0; i + 1 < WIN; i++) held[i] = held[i+1];
    held[WIN-1] = reading;
    if (held_cnt < WIN) held_cnt++;
    st.full     = (held_cnt >= WIN);
    st.critical = 1'b0;
    if (st.full) begin
      st.critical = window_meets_limits();
      if (st.critical && critical_total < COUNT_SAT) critical_total++;
    end
    st.count = CRIT_COUNT_W'(critical_total);
    return st;
  endfunction

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_VALID_MAX:     limits.valid_max     = data[LIMIT_W-1:0];
      REG_LOW_LIMIT:     limits.low_limit     = $signed(data);
      REG_AVG_MIN:       limits.avg_min       = data[LIMIT_W-1:0];
      REG_LOW_COUNT_MAX: limits.low_count_max = data[LOW_CNT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_reading(input logic signed [READING_W-1:0] reading, input logic start);
    while (int'($urandom_range(99)) < in_gap_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid           <= 1'b1;
    in_chan.reading         <= reading;
    in_chan.start_of_series <= start;
    do @(posedge clk); while (!in_chan.ready);
    due_status_q.push_back(predict_window_status(reading, start));
  endtask

  // stop sending and let every pending result drain out
  task automatic settle();
    in_chan.valid <= 1'b0;
    while (due_status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic signed [READING_W-1:0] pick_reading(input logic calm);
    int k;
    int v;
    int lo;
    int hi;
    k  = $urandom_range(99);
    lo = int'(limits.avg_min) - 20;
    hi = int'(limits.valid_max);
    if (calm && k < 85 && hi > lo) v = lo + int'($urandom_range(hi - lo));
    else if (k < 30) v = int'(limits.avg_min) + int'($urandom_range(80)) - 40;
    else if (k < 45) v = int'(limits.valid_max) + int'($urandom_range(4)) - 3;
    else if (k < 60) v = int'(limits.low_limit) + int'($urandom_range(6)) - 3;
    else if (k < 75) v = int'($urandom_range(20)) - 10;
    else return READING_W'($urandom);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return READING_W'(v);
  endfunction

  task automatic pick_settings(input int phase);
    logic [LIMIT_W-1:0]   vmax;
    logic [READING_W-1:0] low;
    logic [LIMIT_W-1:0]   avg;
    logic [LOW_CNT_W-1:0] lcm;
    if (phase == 0) begin
      vmax = 15'h7fff;
      low  = 16'h8000;
      avg  = '0;
      lcm  = 3'd7;
    end else if (phase == 5) begin
      vmax = '0;
      low  = 16'h8000;
      avg  = '0;
      lcm  = 3'd5;
    end else begin
      avg  = LIMIT_W'($urandom_range(300));
      vmax = avg + LIMIT_W'($urandom_range(200));
      low  = READING_W'(int'(avg) - int'($urandom_range(120)));
      lcm  = LOW_CNT_W'($urandom_range(1, 6));
    end
    // upper bits beyond the valid-max, avg-min and low-count registers are junk and must be dropped
    write_reg(REG_VALID_MAX, {1'($urandom), vmax});
    write_reg(REG_LOW_LIMIT, low);
    write_reg(REG_AVG_MIN, {1'($urandom), avg});
    write_reg(REG_LOW_COUNT_MAX, {13'($urandom), lcm});
  endtask

  task automatic test_reset_values();
    send_reading(16'sd100, 1'b1);
    repeat (3) send_reading(16'sd100, 1'b0);
    send_reading(16'sd150, 1'b0);
    send_reading(16'sd151, 1'b0);
    // new series started while the window is full
    send_reading(-16'sd32768, 1'b1);
    send_reading(16'sd32767, 1'b0);
    send_reading(16'sd0, 1'b0);
    send_reading(-16'sd1, 1'b0);
    send_reading(16'sd69, 1'b0);
    settle();
  endtask

  task automatic test_loose_limits();
    write_reg(REG_VALID_MAX, 16'hffff);
    write_reg(REG_LOW_LIMIT, 16'h8000);
    write_reg(REG_AVG_MIN, 16'h8000);
    write_reg(REG_LOW_COUNT_MAX, 16'hffff);
    // first full window all negative: nothing in range; a zero reading follows
    send_reading(-16'sd5, 1'b1);
    send_reading(-16'sd1, 1'b0);
    send_reading(-16'sd32768, 1'b0);
    send_reading(-16'sd2, 1'b0);
    send_reading(-16'sd3, 1'b0);
    send_reading(16'sd0, 1'b0);
    settle();
    // zero low count limit rejects every window
    write_reg(REG_LOW_COUNT_MAX, 16'h0000);
    send_reading(16'sd100, 1'b0);
    settle();
  endtask

  task automatic test_tight_limits();
    write_reg(REG_VALID_MAX, 16'h7fff);
    write_reg(REG_LOW_LIMIT, 16'h7fff);
    write_reg(REG_AVG_MIN, 16'h7fff);
    write_reg(REG_LOW_COUNT_MAX, 16'h0005);
    send_reading(16'sd32767, 1'b1);
    repeat (4) send_reading(16'sd32767, 1'b0);
    send_reading(16'sd32766, 1'b0);
    settle();
  endtask

  task automatic test_random_series();
    logic calm;
    logic start;
    calm = 1'b1;
    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      pick_settings(phase);
      case (phase % 4)
        0: begin in_gap_pct = 0;  out_stall_pct = 0;  end
        1: begin in_gap_pct = 73; out_stall_pct = 0;  end
        2: begin in_gap_pct = 0;  out_stall_pct = 73; end
        default: begin in_gap_pct = 16; out_stall_pct = 16; end
      endcase
      for (int n = 0; n < PHASE_LEN; n++) begin
        start = (n == 0) || ($urandom_range(99) < 4);
        if (start) calm = ($urandom_range(99) < 70);
        send_reading(pick_reading(calm), start);
      end
    end
    settle();
  endtask

  task automatic test_count_run();
    in_gap_pct    = 0;
    out_stall_pct = 0;
    write_reg(REG_VALID_MAX, 16'd150);
    write_reg(REG_LOW_LIMIT, 16'd70);
    write_reg(REG_AVG_MIN, 16'd90);
    write_reg(REG_LOW_COUNT_MAX, 16'd3);
    // every full window is critical, so the count climbs on each reading once the window is full
    send_reading(16'sd100, 1'b1);
    for (int n = 0; n < 40; n++) send_reading(16'sd100, 1'b0);
    settle();
  endtask

  initial begin
    rst_n                   <= 1'b0;
    cfg_we                  <= 1'b0;
    cfg_idx                 <= REG_VALID_MAX;
    cfg_wdata               <= '0;
    in_chan.valid           <= 1'b0;
    in_chan.reading         <= '0;
    in_chan.start_of_series <= 1'b0;
    limits.valid_max     = RST_VALID_MAX;
    limits.low_limit     = RST_LOW_LIMIT;
    limits.avg_min       = RST_AVG_MIN;
    limits.low_count_max = RST_LOW_COUNT_MAX;
    clear_series();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_loose_limits();
    test_tight_limits();
    test_random_series();
    test_count_run();

    settle();
    if (mismatches == 0 && due_status_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sliding_window_critical_detector.f
hdl/swcd_pkg.sv
hdl/swcd_in_if.sv
hdl/swcd_out_if.sv
hdl/swcd_window.sv
hdl/swcd_eval.sv
hdl/sliding_window_critical_detector.sv
tb/tb_top.sv
